[hw/rtl/mpsf_pkg.sv]
// Shared constants, widths and the sequencer state type of the moon phase span fill.
`default_nettype none
package mpsf_pkg;

   localparam int MAX_RADIUS_DEF = 31;

   localparam int COORD_W  = 9;
   localparam int RADIUS_W = 5;
   localparam int ILLUM_W  = 7;
   localparam int OUT_W    = 11;

   // Shared multiplier operand and product widths.
   localparam int MUL_W  = 13;
   localparam int PROD_W = 2 * MUL_W;

   // Square root of R*R - dy*dy fits in the radius width.
   localparam int ROOT_W = RADIUS_W;
   localparam int SQ_W   = 2 * RADIUS_W;
   localparam int BIT_W  = 3;

   localparam int ILLUM_FULL = 100;
   localparam int COEF_W     = 7;

   // Division by 100 as a multiply by ceil(2^19 / 100) and a shift. Exact for
   // every product of a coefficient up to 100 and a half-chord up to 31.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int DIVIN_W     = 12;
   localparam int MAG_W       = PROD_W - RECIP_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RSQ,
      ST_DSQ,
      ST_SUB,
      ST_TRY,
      ST_CHK,
      ST_SCL,
      ST_DIV,
      ST_QUO,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

[hw/rtl/mpsf_mul.sv]
// Shared unsigned multiplier with a registered product.
`default_nettype none
module mpsf_mul (
   input  wire logic                         clock,
   input  wire logic [mpsf_pkg::MUL_W-1:0]   op_a,
   input  wire logic [mpsf_pkg::MUL_W-1:0]   op_b,
   output logic      [mpsf_pkg::PROD_W-1:0]  product
);

   logic [mpsf_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= mpsf_pkg::PROD_W'(op_a) * mpsf_pkg::PROD_W'(op_b);
   end

   assign product = product_ff;

endmodule
`default_nettype wire

[hw/rtl/moon_phase_span_fill.sv]
// Top level of the moon phase span fill: row sequencer, datapath and result register.
`default_nettype none
// The block takes one disc per request beat: centre column and row, radius,
// illuminated percentage and waxing flag. It answers with one response beat
// per pixel row of the disc, top row first, 2R+1 beats in all, the bottom
// one flagged with rsp_last_row. Each beat carries the row and the first and
// last lit column, all as 11-bit two's complement values.
// A request is taken only while the sequencer is idle; req_stall is high
// for the whole disc. Every row runs through one shared 13x13 multiplier:
// one product for dy*dy, five square-and-compare trials for the bit-by-bit
// floor square root, one for the terminator scaling and one for the
// reciprocal divide by 100, whose quotient is then held in a register.
// The response register decouples the sides: the next row is computed
// while the previous beat waits, and the sequencer only holds when a
// finished row finds the register still full. Radii above MAX_RADIUS and
// percentages above 100 saturate.
// A synchronous reset returns the sequencer to idle with no response
// pending; no clearing sweep is needed.
module moon_phase_span_fill #(
   parameter int MAX_RADIUS = mpsf_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [mpsf_pkg::COORD_W-1:0]  req_center_x,
   input  wire logic        [mpsf_pkg::COORD_W-1:0]  req_center_y,
   input  wire logic        [mpsf_pkg::RADIUS_W-1:0] req_radius,
   input  wire logic        [mpsf_pkg::ILLUM_W-1:0]  req_illum_pct,
   input  wire logic                                req_waxing,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [mpsf_pkg::OUT_W-1:0]    rsp_row_y,
   output logic signed      [mpsf_pkg::OUT_W-1:0]    rsp_span_start,
   output logic signed      [mpsf_pkg::OUT_W-1:0]    rsp_span_end,
   output logic                                     rsp_last_row
);

   // Row counter runs from 0 to 2R.
   localparam int KW = $clog2(2 * MAX_RADIUS + 1);

   localparam int OW = mpsf_pkg::OUT_W;

   mpsf_pkg::state_type state_ff, state_in;

   logic [mpsf_pkg::COORD_W-1:0]  cx_ff, cy_ff;
   logic [mpsf_pkg::RADIUS_W-1:0] r_ff;
   logic [mpsf_pkg::COEF_W-1:0]   coef_ff;
   logic                          coef_neg_ff;
   logic                          waxing_ff;
   logic [KW-1:0]                 k_ff;
   logic [mpsf_pkg::SQ_W-1:0]     rsq_ff, v_ff;
   logic [mpsf_pkg::ROOT_W-1:0]   root_ff;
   logic [mpsf_pkg::BIT_W-1:0]    bit_ff;
   logic [mpsf_pkg::MAG_W-1:0]    mag_ff;

   logic                          rsp_valid_ff;
   logic [OW-1:0]                 row_y_ff, start_ff, end_ff;
   logic                          last_ff;

   logic [mpsf_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic [mpsf_pkg::PROD_W-1:0]   product;

   logic                          req_take, rsp_take, rsp_free;
   logic [mpsf_pkg::RADIUS_W-1:0] r_sat;
   logic [mpsf_pkg::ILLUM_W-1:0]  illum_sat;
   logic [7:0]                    illum2;
   logic [KW-1:0]                 r_k, dy_abs;
   logic                          last_k;
   logic [mpsf_pkg::ROOT_W-1:0]   trial;
   logic [mpsf_pkg::MAG_W-1:0]    mag;
   logic [OW-1:0]                 xt, hw, cx_w, row_y_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   // The response register can take a new row this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign r_sat = (req_radius > mpsf_pkg::RADIUS_W'(MAX_RADIUS))
                ? mpsf_pkg::RADIUS_W'(MAX_RADIUS) : req_radius;
   assign illum_sat = (req_illum_pct > mpsf_pkg::ILLUM_W'(mpsf_pkg::ILLUM_FULL))
                    ? mpsf_pkg::ILLUM_W'(mpsf_pkg::ILLUM_FULL) : req_illum_pct;
   assign illum2 = {illum_sat, 1'b0};

   assign r_k    = KW'(r_ff);
   assign dy_abs = (k_ff >= r_k) ? (k_ff - r_k) : (r_k - k_ff);
   assign last_k = ({1'b0, k_ff} == {r_k, 1'b0});
   assign trial  = root_ff | (mpsf_pkg::ROOT_W'(1) << bit_ff);

   // The quotient is valid for one cycle only, so it is held in mag_ff.
   assign mag  = product[mpsf_pkg::PROD_W-1:mpsf_pkg::RECIP_SHIFT];
   assign xt   = coef_neg_ff ? (OW'(0) - OW'(mag_ff)) : OW'(mag_ff);
   assign hw   = OW'(root_ff);
   assign cx_w = OW'(cx_ff);
   assign row_y_in = OW'(cy_ff) + OW'(k_ff) - OW'(r_ff);

   mpsf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpsf_pkg::ST_IDLE: if (req_take) state_in = mpsf_pkg::ST_RSQ;
         mpsf_pkg::ST_RSQ:  state_in = mpsf_pkg::ST_DSQ;
         mpsf_pkg::ST_DSQ:  state_in = mpsf_pkg::ST_SUB;
         mpsf_pkg::ST_SUB:  state_in = mpsf_pkg::ST_TRY;
         mpsf_pkg::ST_TRY:  state_in = mpsf_pkg::ST_CHK;
         mpsf_pkg::ST_CHK: begin
            if (bit_ff == '0) state_in = mpsf_pkg::ST_SCL;
            else              state_in = mpsf_pkg::ST_TRY;
         end
         mpsf_pkg::ST_SCL:  state_in = mpsf_pkg::ST_DIV;
         mpsf_pkg::ST_DIV:  state_in = mpsf_pkg::ST_QUO;
         mpsf_pkg::ST_QUO:  state_in = mpsf_pkg::ST_FIN;
         mpsf_pkg::ST_FIN: begin
            if (rsp_free) begin
               if (last_k) state_in = mpsf_pkg::ST_IDLE;
               else        state_in = mpsf_pkg::ST_DSQ;
            end
         end
         default: state_in = mpsf_pkg::ST_IDLE;
      endcase
   end

   // Outputs: request stall and the shared multiplier's operands.
   always_comb begin
      req_stall = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         mpsf_pkg::ST_IDLE: req_stall = 1'b0;
         mpsf_pkg::ST_RSQ: begin
            mul_a = mpsf_pkg::MUL_W'(r_ff);
            mul_b = mpsf_pkg::MUL_W'(r_ff);
         end
         mpsf_pkg::ST_DSQ: begin
            mul_a = mpsf_pkg::MUL_W'(dy_abs);
            mul_b = mpsf_pkg::MUL_W'(dy_abs);
         end
         mpsf_pkg::ST_TRY: begin
            mul_a = mpsf_pkg::MUL_W'(trial);
            mul_b = mpsf_pkg::MUL_W'(trial);
         end
         mpsf_pkg::ST_SCL: begin
            mul_a = mpsf_pkg::MUL_W'(coef_ff);
            mul_b = mpsf_pkg::MUL_W'(root_ff);
         end
         mpsf_pkg::ST_DIV: begin
            mul_a = mpsf_pkg::MUL_W'(product[mpsf_pkg::DIVIN_W-1:0]);
            mul_b = mpsf_pkg::MUL_W'(mpsf_pkg::RECIP_100);
         end
         mpsf_pkg::ST_SUB, mpsf_pkg::ST_CHK, mpsf_pkg::ST_QUO, mpsf_pkg::ST_FIN: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpsf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Job operands and per-row working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         if (req_take) begin
            k_ff <= '0;
         end else if (state_ff == mpsf_pkg::ST_FIN && rsp_free) begin
            k_ff <= last_k ? '0 : k_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cx_ff     <= req_center_x;
         cy_ff     <= req_center_y;
         r_ff      <= r_sat;
         waxing_ff <= req_waxing;
         // The sign of 100 - 2*illum is kept apart from its magnitude.
         if (illum2 > 8'(mpsf_pkg::ILLUM_FULL)) begin
            coef_neg_ff <= 1'b1;
            coef_ff     <= mpsf_pkg::COEF_W'(illum2 - 8'(mpsf_pkg::ILLUM_FULL));
         end else begin
            coef_neg_ff <= 1'b0;
            coef_ff     <= mpsf_pkg::COEF_W'(8'(mpsf_pkg::ILLUM_FULL) - illum2);
         end
      end
      case (state_ff)
         mpsf_pkg::ST_DSQ: begin
            if (k_ff == '0) rsq_ff <= product[mpsf_pkg::SQ_W-1:0];
         end
         mpsf_pkg::ST_SUB: begin
            // |dy| never exceeds R, so this stays non-negative.
            v_ff    <= rsq_ff - product[mpsf_pkg::SQ_W-1:0];
            root_ff <= '0;
            bit_ff  <= mpsf_pkg::BIT_W'(mpsf_pkg::ROOT_W - 1);
         end
         mpsf_pkg::ST_CHK: begin
            if (product <= mpsf_pkg::PROD_W'(v_ff)) root_ff <= trial;
            bit_ff <= bit_ff - mpsf_pkg::BIT_W'(1);
         end
         mpsf_pkg::ST_QUO: begin
            mag_ff <= mag;
         end
         default: begin
         end
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == mpsf_pkg::ST_FIN && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mpsf_pkg::ST_FIN && rsp_free) begin
         row_y_ff <= row_y_in;
         last_ff  <= last_k;
         if (waxing_ff) begin
            start_ff <= cx_w + xt;
            end_ff   <= cx_w + hw;
         end else begin
            start_ff <= cx_w - hw;
            end_ff   <= cx_w - xt;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_y      = $signed(row_y_ff);
   assign rsp_span_start = $signed(start_ff);
   assign rsp_span_end   = $signed(end_ff);
   assign rsp_last_row   = last_ff;

endmodule
`default_nettype wire
